### src/mlc_pkg.sv
package mlc_pkg;

  // Request codes carried on the input tuser
  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_REPL   = 3'd2,
    REQ_INVAL  = 3'd3,
    REQ_FLUSH  = 3'd4,
    REQ_RFILL  = 3'd5,
    REQ_WFILL  = 3'd6
  } req_t;

  // Bus action codes
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RD   = 2'd1,
    ACT_RDX  = 2'd2
  } act_t;

  // Line coherence state, held one-hot
  typedef enum logic [3:0] {
    ST_I = 4'b0001,
    ST_S = 4'b0010,
    ST_E = 4'b0100,
    ST_M = 4'b1000
  } mesi_t;

  // Encoded line state as reported on the result
  localparam logic [1:0] LS_I = 2'd0;
  localparam logic [1:0] LS_S = 2'd1;
  localparam logic [1:0] LS_E = 2'd2;
  localparam logic [1:0] LS_M = 2'd3;

  // Counter bump strobes from the step logic
  typedef struct packed {
    logic hit;
    logic miss;
    logic flush;
    logic evict;
    logic dirty_evict;
    logic inval;
  } cnt_inc_t;

  function automatic logic [1:0] enc_state(mesi_t st);
    logic [1:0] code;
    case (st)
      ST_S:    code = LS_S;
      ST_E:    code = LS_E;
      ST_M:    code = LS_M;
      default: code = LS_I;
    endcase
    return code;
  endfunction

endpackage

### src/mlc_step.sv
module mlc_step #(
  parameter int TAG_BITS  = 20,
  parameter int NODE_BITS = 3
) (
  input  mlc_pkg::req_t          req,
  input  logic                   repl_wr,
  input  logic [TAG_BITS-1:0]    new_tag,
  input  logic [NODE_BITS-1:0]   node,
  input  logic                   exclusive,
  input  mlc_pkg::mesi_t         cur_st,
  input  logic                   cur_dirty,
  input  logic [TAG_BITS-1:0]    cur_tag,
  input  logic [NODE_BITS-1:0]   cur_node,
  output mlc_pkg::mesi_t         nxt_st,
  output logic                   nxt_dirty,
  output logic [TAG_BITS-1:0]    nxt_tag,
  output logic [NODE_BITS-1:0]   nxt_node,
  output mlc_pkg::act_t          act,
  output mlc_pkg::cnt_inc_t      inc
);
  import mlc_pkg::*;

  mesi_t acc_st;
  logic  acc_wr;

  // Processor access: a replace starts from I with the write flag of the beat
  always_comb begin
    acc_st = (req == REQ_REPL) ? ST_I : cur_st;
    acc_wr = (req == REQ_WRITE) || ((req == REQ_REPL) && repl_wr);
  end

  always_comb begin
    nxt_st    = cur_st;
    nxt_dirty = cur_dirty;
    nxt_tag   = cur_tag;
    nxt_node  = cur_node;
    act       = ACT_NONE;
    inc       = '0;
    case (req)
      REQ_READ, REQ_WRITE, REQ_REPL: begin
        nxt_node = node;
        if (req == REQ_WRITE) begin
          nxt_dirty = 1'b1;
        end
        // Count the eviction of a valid line and flush it if dirty
        if (req == REQ_REPL) begin
          nxt_tag   = new_tag;
          nxt_dirty = repl_wr;
          if (cur_st != ST_I) begin
            inc.evict       = 1'b1;
            inc.flush       = cur_dirty;
            inc.dirty_evict = cur_dirty;
          end
        end
        // Resolve hit or miss against the starting state
        case (acc_st)
          ST_M: begin
            inc.hit = 1'b1;
            nxt_st  = ST_M;
          end
          ST_E: begin
            inc.hit = 1'b1;
            nxt_st  = acc_wr ? ST_M : ST_E;
          end
          ST_S: begin
            if (acc_wr) begin
              inc.miss = 1'b1;
              nxt_st   = ST_M;
              act      = ACT_RDX;
            end else begin
              inc.hit = 1'b1;
              nxt_st  = ST_S;
            end
          end
          default: begin
            inc.miss = 1'b1;
            nxt_st   = acc_wr ? ST_M : ST_E;
            act      = acc_wr ? ACT_RDX : ACT_RD;
          end
        endcase
      end
      REQ_INVAL: begin
        inc.inval = 1'b1;
        nxt_st    = ST_I;
      end
      REQ_FLUSH: begin
        // Downgrade owned lines; M writes back
        if (cur_st == ST_M) begin
          inc.flush = 1'b1;
          nxt_st    = ST_S;
        end else if (cur_st == ST_E) begin
          nxt_st = ST_S;
        end
      end
      REQ_RFILL: begin
        nxt_st = exclusive ? ST_E : ST_S;
      end
      REQ_WFILL: begin
        nxt_st = ST_M;
      end
      default: begin
        nxt_st = cur_st;
      end
    endcase
  end

endmodule

### src/mesi_line_controller_top.sv
// Channel | Direction | tdata / tuser contents
// in_     | slave     | tuser: req_type; tdata: repl_wr, new_tag, node, exclusive
// out_    | master    | tdata: bus_action, line_state, dirty_out, tag_out, node_out,
//         |           |        six event counters
//
// One beat per cycle sustained while out_tready stays high; a result passes
// through the input register, then the result register.
// The line state and counters are updated when a beat moves from the input
// register into the result register, so each result reflects every earlier beat.
// rst_n (synchronous, active low) clears the line to I with tag, node, dirty mark
// and all counters at zero, and empties both registers.
// A stalled result holds the result register; the input register still takes a
// beat and waits there, so the pipeline stops only when both are full.
module mesi_line_controller_top #(
  parameter int TAG_BITS   = 20,
  parameter int NODE_COUNT = 8,
  parameter int COUNT_BITS = 32,
  localparam int NODE_BITS = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
  localparam int IN_BITS   = 1 + TAG_BITS + NODE_BITS + 1,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 + 2 + 1 + TAG_BITS + NODE_BITS + 6 * COUNT_BITS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // repl_wr, new_tag, node, exclusive (from bit 0 up), zero padded
  input  logic [IN_W-1:0]  in_tdata,
  // req_type
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // bus_action, line_state, dirty_out, tag_out, node_out, hits, misses,
  // flush_total, eviction_total, dirty_eviction_total, invalidation_total
  // (from bit 0 up), zero padded
  output logic [OUT_W-1:0] out_tdata
);
  import mlc_pkg::*;

  // Input register
  logic                 s1_vld_r;
  req_t                 s1_req_r;
  logic                 s1_wr_r;
  logic [TAG_BITS-1:0]  s1_tag_r;
  logic [NODE_BITS-1:0] s1_node_r;
  logic                 s1_excl_r;

  // Line state
  mesi_t                st_r, st_nxt;
  logic                 dirty_r, dirty_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [NODE_BITS-1:0] node_r, node_nxt;
  logic [COUNT_BITS-1:0] hit_r, miss_r, flush_r, evict_r, devict_r, inval_r;
  logic [COUNT_BITS-1:0] hit_nxt, miss_nxt, flush_nxt, evict_nxt, devict_nxt, inval_nxt;

  // Result register
  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  act_t     act;
  cnt_inc_t inc;
  logic     s1_adv;
  logic     in_acc;

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= req_t'(in_tuser);
      s1_wr_r   <= in_tdata[0];
      s1_tag_r  <= in_tdata[TAG_BITS:1];
      s1_node_r <= in_tdata[TAG_BITS+NODE_BITS:TAG_BITS+1];
      s1_excl_r <= in_tdata[TAG_BITS+NODE_BITS+1];
    end
  end

  mlc_step #(
    .TAG_BITS  (TAG_BITS),
    .NODE_BITS (NODE_BITS)
  ) u_step (
    .req       (s1_req_r),
    .repl_wr   (s1_wr_r),
    .new_tag   (s1_tag_r),
    .node      (s1_node_r),
    .exclusive (s1_excl_r),
    .cur_st    (st_r),
    .cur_dirty (dirty_r),
    .cur_tag   (tag_r),
    .cur_node  (node_r),
    .nxt_st    (st_nxt),
    .nxt_dirty (dirty_nxt),
    .nxt_tag   (tag_nxt),
    .nxt_node  (node_nxt),
    .act       (act),
    .inc       (inc)
  );

  // Advance the counters
  always_comb begin
    hit_nxt    = hit_r + COUNT_BITS'(inc.hit);
    miss_nxt   = miss_r + COUNT_BITS'(inc.miss);
    flush_nxt  = flush_r + COUNT_BITS'(inc.flush);
    evict_nxt  = evict_r + COUNT_BITS'(inc.evict);
    devict_nxt = devict_r + COUNT_BITS'(inc.dirty_evict);
    inval_nxt  = inval_r + COUNT_BITS'(inc.inval);
  end

  // Pack the result beat
  assign out_data_nxt = OUT_W'({inval_nxt, devict_nxt, evict_nxt, flush_nxt,
                                miss_nxt, hit_nxt, node_nxt, tag_nxt, dirty_nxt,
                                enc_state(st_nxt), act});

  // Commit the line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_I;
      dirty_r  <= 1'b0;
      tag_r    <= '0;
      node_r   <= '0;
      hit_r    <= '0;
      miss_r   <= '0;
      flush_r  <= '0;
      evict_r  <= '0;
      devict_r <= '0;
      inval_r  <= '0;
    end else if (s1_adv) begin
      st_r     <= st_nxt;
      dirty_r  <= dirty_nxt;
      tag_r    <= tag_nxt;
      node_r   <= node_nxt;
      hit_r    <= hit_nxt;
      miss_r   <= miss_nxt;
      flush_r  <= flush_nxt;
      evict_r  <= evict_nxt;
      devict_r <= devict_nxt;
      inval_r  <= inval_nxt;
    end
  end

  // Hold or load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import mlc_pkg::*;

  localparam int IN_W        = 32;
  localparam int OUT_W       = 224;
  localparam int OUT_USED    = 220;
  localparam int STALL_LIMIT = 2000;

  // Request code that the block has to ignore
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // Input tdata fields, replace write flag in bit 0
  typedef struct packed {
    logic        excl;
    logic [2:0]  node;
    logic [19:0] tag;
    logic        wr;
  } line_req_t;

  // Result tdata fields, bus_action in bits 1:0
  typedef struct packed {
    logic [31:0] inval_cnt;
    logic [31:0] dirty_evict_cnt;
    logic [31:0] evict_cnt;
    logic [31:0] flush_cnt;
    logic [31:0] miss_cnt;
    logic [31:0] hit_cnt;
    logic [2:0]  node;
    logic [19:0] tag;
    logic        dirty;
    logic [1:0]  state;
    logic [1:0]  action;
  } line_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [2:0]       in_tuser = REQ_READ;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  line_result_t line_now = '0;
  line_result_t expected_lines[$];
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;

  mesi_line_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Processor read or write against the current line state
  function automatic act_t processor_access(logic wr);
    act_t act;
    act = ACT_NONE;
    case (line_now.state)
      LS_M: line_now.hit_cnt += 1;
      LS_E: begin
        if (wr) line_now.state = LS_M;
        line_now.hit_cnt += 1;
      end
      LS_S: begin
        if (wr) begin
          line_now.miss_cnt += 1;
          line_now.state = LS_M;
          act = ACT_RDX;
        end else begin
          line_now.hit_cnt += 1;
        end
      end
      default: begin
        line_now.miss_cnt += 1;
        if (wr) begin
          line_now.state = LS_M;
          act = ACT_RDX;
        end else begin
          line_now.state = LS_E;
          act = ACT_RD;
        end
      end
    endcase
    return act;
  endfunction

  // Advance the line by one coherence event and return the result beat
  function automatic line_result_t mesi_predict(logic [2:0] req, line_req_t rq);
    line_now.action = ACT_NONE;
    case (req)
      REQ_READ: begin
        line_now.node = rq.node;
        line_now.action = processor_access(1'b0);
      end
      REQ_WRITE: begin
        line_now.dirty = 1'b1;
        line_now.node = rq.node;
        line_now.action = processor_access(1'b1);
      end
      REQ_REPL: begin
        if (line_now.state != LS_I) begin
          if (line_now.dirty) begin
            line_now.flush_cnt += 1;
            line_now.dirty_evict_cnt += 1;
          end
          line_now.evict_cnt += 1;
        end
        line_now.tag = rq.tag;
        line_now.dirty = rq.wr;
        line_now.node = rq.node;
        line_now.state = LS_I;
        line_now.action = processor_access(rq.wr);
      end
      REQ_INVAL: begin
        line_now.inval_cnt += 1;
        line_now.state = LS_I;
      end
      REQ_FLUSH: begin
        if (line_now.state == LS_M) begin
          line_now.flush_cnt += 1;
          line_now.state = LS_S;
        end else if (line_now.state == LS_E) begin
          line_now.state = LS_S;
        end
      end
      REQ_RFILL: line_now.state = rq.excl ? LS_E : LS_S;
      REQ_WFILL: line_now.state = LS_M;
      default: ;
    endcase
    return line_now;
  endfunction

  // Offer one event beat, with random gaps before it, and hold until taken
  task automatic send_event(logic [2:0] req, logic wr, logic [19:0] tag,
                            logic [2:0] node, logic excl);
    line_req_t rq;
    rq.excl = excl;
    rq.node = node;
    rq.tag  = tag;
    rq.wr   = wr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - 25){1'b0}}, rq};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    expected_lines.push_back(mesi_predict(req, rq));
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare one result beat against the oldest prediction
  task automatic check_line_result(logic [OUT_W-1:0] data);
    line_result_t got, want;
    got = data[OUT_USED-1:0];
    if (expected_lines.size() == 0) begin
      $error("result beat with no prediction pending");
      error_count++;
      return;
    end
    want = expected_lines.pop_front();
    compare_field("bus_action", want.action, got.action);
    compare_field("line_state", want.state, got.state);
    compare_field("dirty_out", want.dirty, got.dirty);
    compare_field("tag_out", want.tag, got.tag);
    compare_field("node_out", want.node, got.node);
    compare_field("hits", want.hit_cnt, got.hit_cnt);
    compare_field("misses", want.miss_cnt, got.miss_cnt);
    compare_field("flush_total", want.flush_cnt, got.flush_cnt);
    compare_field("eviction_total", want.evict_cnt, got.evict_cnt);
    compare_field("dirty_eviction_total", want.dirty_evict_cnt, got.dirty_evict_cnt);
    compare_field("invalidation_total", want.inval_cnt, got.inval_cnt);
  endtask

  // Take result beats and drive out_tready: long hold-off first, else random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_line_result(out_tdata);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[mesi_line_controller_top] ERROR");
        $finish;
      end
    end
  end

  // Walk the line through a directed sequence of MESI transitions
  task automatic test_directed();
    send_idle_pct = 26;
    recv_idle_pct = 55;
    send_event(REQ_READ,   1'b0, 20'h00000, 3'd0, 1'b0); // read miss in I
    send_event(REQ_READ,   1'b1, 20'hfffff, 3'd7, 1'b1); // read hit in E
    send_event(REQ_WRITE,  1'b0, 20'h00000, 3'd3, 1'b0); // silent upgrade E to M
    send_event(REQ_READ,   1'b0, 20'h00000, 3'd5, 1'b0); // hit in M
    send_event(REQ_FLUSH,  1'b0, 20'h00000, 3'd0, 1'b0); // M to S, counts a flush
    send_event(REQ_FLUSH,  1'b1, 20'hfffff, 3'd7, 1'b1); // ignored in S
    send_event(REQ_READ,   1'b0, 20'h00000, 3'd1, 1'b0); // read hit in S
    send_event(REQ_WRITE,  1'b0, 20'h00000, 3'd6, 1'b0); // write miss in S
    send_event(REQ_INVAL,  1'b0, 20'h00000, 3'd0, 1'b0); // M to I, dirty kept
    send_event(REQ_INVAL,  1'b1, 20'hfffff, 3'd7, 1'b1); // counts in I as well
    send_event(REQ_FLUSH,  1'b0, 20'h00000, 3'd0, 1'b0); // ignored in I
    send_event(REQ_RFILL,  1'b0, 20'h00000, 3'd0, 1'b1); // exclusive fill to E
    send_event(REQ_FLUSH,  1'b0, 20'h00000, 3'd0, 1'b0); // E to S, no flush count
    send_event(REQ_RFILL,  1'b0, 20'h00000, 3'd0, 1'b0); // shared fill to S
    send_event(REQ_WFILL,  1'b0, 20'h00000, 3'd0, 1'b0); // write fill to M
    send_event(REQ_REPL,   1'b1, 20'hfffff, 3'd7, 1'b0); // dirty eviction, write
    send_event(REQ_REPL,   1'b0, 20'h00000, 3'd0, 1'b1); // dirty eviction, read
    send_event(REQ_REPL,   1'b0, 20'h5a5a5, 3'd2, 1'b0); // clean eviction from E
    send_event(REQ_INVAL,  1'b0, 20'h00000, 3'd0, 1'b0);
    send_event(REQ_REPL,   1'b1, 20'ha5a5a, 3'd4, 1'b0); // replace in I, no eviction
    send_event(REQ_UNUSED, 1'b1, 20'hfffff, 3'd7, 1'b1); // unused code, no change
    send_event(REQ_INVAL,  1'b0, 20'h00000, 3'd0, 1'b0);
    send_event(REQ_WRITE,  1'b0, 20'h00000, 3'd7, 1'b0); // write miss in I
  endtask

  function automatic logic [2:0] pick_request();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 22) return REQ_READ;
    if (roll < 40) return REQ_WRITE;
    if (roll < 55) return REQ_REPL;
    if (roll < 63) return REQ_INVAL;
    if (roll < 75) return REQ_FLUSH;
    if (roll < 85) return REQ_RFILL;
    if (roll < 96) return REQ_WFILL;
    return REQ_UNUSED;
  endfunction

  // Random event mix with the given idle rates on each side
  task automatic test_random_traffic(int unsigned count, int unsigned snd_pct,
                                     int unsigned rcv_pct);
    logic [19:0] tag;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) begin
      case ($urandom_range(5))
        0:       tag = 20'h00000;
        1:       tag = 20'hfffff;
        default: tag = 20'($urandom);
      endcase
      send_event(pick_request(), 1'($urandom_range(1)), tag, 3'($urandom_range(7)),
                 1'($urandom_range(1)));
    end
  endtask

  // Hold the receiver off long enough for the block to fill and stall its input
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 300;
    repeat (40) begin
      send_event(pick_request(), 1'($urandom_range(1)), 20'($urandom),
                 3'($urandom_range(7)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(600, 26, 55);
    test_random_traffic(600, 55, 26);
    test_random_traffic(600, 0, 0);
    test_back_pressure();
    in_tvalid <= 1'b0;
    // drain, then let the pipeline settle
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("[mesi_line_controller_top] OK");
    end else begin
      $display("[mesi_line_controller_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/mlc_pkg.sv
src/mlc_step.sv
src/mesi_line_controller_top.sv
tb/tb.sv
